// ----- hw/rtl/mns_pkg.sv -----
// Shared types and constants of the nearest-record sorter.
// Used by mns_map_div, manhattan_nearest_sort and the testbench; depends on nothing.
package mns_pkg;

   // Largest number of record slots by default.
   localparam int DEFAULT_MAX_RECORDS = 1024;

   // Map window edges in 1e-5 degree units.
   localparam int WEST_EDGE  = -11368652;
   localparam int EAST_EDGE  = -11333496;
   localparam int NORTH_EDGE = 5361858;
   localparam int SOUTH_EDGE = 5340953;

   // Map size is 2048 pixels, applied as a left shift.
   localparam int MAP_SHIFT = 11;

   // Span magnitudes; the y span runs north to south but is taken as a positive magnitude.
   localparam int X_SPAN = EAST_EDGE - WEST_EDGE;
   localparam int Y_SPAN = NORTH_EDGE - SOUTH_EDGE;

   // Request kinds carried in req_tuser.
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_FETCH = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   // Response kinds carried in rsp_tuser.
   localparam logic [1:0] STAT_LOADED  = 2'd0;
   localparam logic [1:0] STAT_SORTED  = 2'd1;
   localparam logic [1:0] STAT_MATCH   = 2'd2;
   localparam logic [1:0] STAT_NOMATCH = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_MIN_RATING   = 1'b0;
   localparam logic CSR_RECORD_COUNT = 1'b1;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD_DIV,
      S_Q_RDPOS,
      S_Q_DIST,
      S_Q_SHIFT,
      S_Q_PLACE,
      S_F_RDORD,
      S_F_RDREC,
      S_F_CHECK,
      S_RESP
   } mns_state_type;

   // Result of one coordinate mapping.
   typedef struct packed {
      logic              done;
      logic signed [15:0] value;
   } mns_div_out_type;

endpackage

// ----- hw/rtl/manhattan_nearest_sort.sv -----
// Nearest-record sorter by Manhattan distance on a 2048-pixel map.
// Channels: req_* takes one request per transfer, its kind in req_tuser
// (load record, start query at cursor, fetch next match); rsp_* returns one
// response per load, query or fetch, its status in rsp_tuser. Unused request
// kind three is taken and answered with nothing. csr_* writes min_rating
// (index 0) and record_count (index 1); the user must write them only while
// the block is idle, which the block itself does not enforce. A load answers
// once the coordinate mappers finish. A query sorts the records by insertion,
// moving larger entries up one rank at a time; an empty query reads none.
// A fetch answers with the next sorted entry whose rating class reaches
// min_rating, or with no match when the list runs out.
// One request is worked on at a time; the next is taken from the cycle in
// which the response appears. A waiting response does not block the input,
// but no new response is written until rsp_tready takes the old one.
// Reset clears the registers to min_rating 1 and record_count 1024 and
// empties the sorted list; record store contents are undefined until loaded.
// Depends on mns_pkg, mns_ram and mns_map_div.
module manhattan_nearest_sort #(
   parameter int MAX_RECORDS = mns_pkg::DEFAULT_MAX_RECORDS
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // rec_index[9:0], rec_lon[34:10], rec_lat[59:35], rec_rating[63:60],
   // cursor_x[75:64], cursor_y[87:76]
   input  logic [87:0] req_tdata,
   // action[1:0]
   input  logic [1:0]  req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // found_index[9:0], found_distance[25:10], zero fill above
   output logic [31:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [10:0] csr_data
);

   localparam int AW    = $clog2(MAX_RECORDS);
   localparam int CW    = $clog2(MAX_RECORDS + 1);
   localparam int REC_W = 35;
   localparam int ORD_W = AW + 16;

   // Manhattan distance, saturated to 16 bits.
   function automatic logic [15:0] manhattan(input logic [11:0] cx, input logic [11:0] cy,
                                             input logic signed [15:0] px,
                                             input logic signed [15:0] py);
      logic signed [17:0] dx;
      logic signed [17:0] dy;
      logic [16:0]        ax;
      logic [16:0]        ay;
      logic [17:0]        s;
      dx = $signed({6'b0, cx}) - 18'(px);
      dy = $signed({6'b0, cy}) - 18'(py);
      ax = dx[17] ? 17'(-dx) : 17'(dx);
      ay = dy[17] ? 17'(-dy) : 17'(dy);
      s  = 18'(ax) + 18'(ay);
      return (s > 18'd65535) ? 16'hFFFF : s[15:0];
   endfunction

   // Rating class max((r+1)/2, 1), at most 7.
   function automatic logic [2:0] rating_class(input logic [3:0] r);
      logic [4:0] c;
      c = (5'(r) + 5'd1) >> 1;
      if (c > 5'd7) begin
         return 3'd7;
      end else if (c == 5'd0) begin
         return 3'd1;
      end
      return c[2:0];
   endfunction

   // Request fields.
   logic [9:0]         rec_index;
   logic signed [24:0] rec_lon;
   logic signed [24:0] rec_lat;
   logic [3:0]         rec_rating;
   logic [11:0]        cursor_x;
   logic [11:0]        cursor_y;
   logic [1:0]         action;
   logic               req_xfer;

   assign rec_index  = req_tdata[9:0];
   assign rec_lon    = $signed(req_tdata[34:10]);
   assign rec_lat    = $signed(req_tdata[59:35]);
   assign rec_rating = req_tdata[63:60];
   assign cursor_x   = req_tdata[75:64];
   assign cursor_y   = req_tdata[87:76];
   assign action     = req_tuser;

   // Registers.
   mns_pkg::mns_state_type state_ff, state_in;
   logic [2:0]    min_rating_ff;
   logic [10:0]   record_count_ff;
   logic [CW-1:0] sorted_ff, sorted_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    pend_ff, pend_in;
   logic [AW-1:0] ld_slot_ff;
   logic          ld_ok_ff;
   logic [2:0]    cls_ff;
   logic [11:0]   cx_ff;
   logic [11:0]   cy_ff;
   logic [CW-1:0] n_ff, n_in;
   logic [AW-1:0] i_ff, i_in;
   logic [AW-1:0] j_ff, j_in;
   logic [15:0]   dist_ff, dist_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [15:0]   fdist_ff, fdist_in;
   logic [1:0]    rsp_status_ff;
   logic [9:0]    rsp_index_ff;
   logic [15:0]   rsp_dist_ff;

   // Memory ports.
   logic               rec_wr_en;
   logic [REC_W-1:0]   rec_wr_data;
   logic               rec_rd_en;
   logic [AW-1:0]      rec_rd_addr;
   logic [REC_W-1:0]   rec_rd_data;
   logic               ord_wr_en;
   logic [AW-1:0]      ord_wr_addr;
   logic [ORD_W-1:0]   ord_wr_data;
   logic               ord_rd_en;
   logic [AW-1:0]      ord_rd_addr;
   logic [ORD_W-1:0]   ord_rd_data;

   mns_pkg::mns_div_out_type div_x;
   mns_pkg::mns_div_out_type div_y;

   logic [15:0]   new_dist;
   logic [15:0]   ord_dist;
   logic [AW-1:0] ord_slot;
   logic          last_i;
   logic          emit;
   logic [CW-1:0] n_req;

   assign req_tready = (state_ff == mns_pkg::S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Coordinate mappers.
   mns_map_div #(
      .ORIGIN (mns_pkg::WEST_EDGE),
      .DIVISOR(mns_pkg::X_SPAN),
      .NEGATE (1'b0)
   ) u_div_x (
      .clock (clock),
      .reset (reset),
      .start (req_xfer && action == mns_pkg::ACT_LOAD),
      .coord (rec_lon),
      .result(div_x)
   );

   mns_map_div #(
      .ORIGIN (mns_pkg::NORTH_EDGE),
      .DIVISOR(mns_pkg::Y_SPAN),
      .NEGATE (1'b1)
   ) u_div_y (
      .clock (clock),
      .reset (reset),
      .start (req_xfer && action == mns_pkg::ACT_LOAD),
      .coord (rec_lat),
      .result(div_y)
   );

   // Record store: class, y and x per slot.
   mns_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_rec_ram (
      .clock  (clock),
      .wr_en  (rec_wr_en),
      .wr_addr(ld_slot_ff),
      .wr_data(rec_wr_data),
      .rd_en  (rec_rd_en),
      .rd_addr(rec_rd_addr),
      .rd_data(rec_rd_data)
   );

   // Sorted list: slot and distance per rank.
   mns_ram #(.WIDTH(ORD_W), .DEPTH(MAX_RECORDS)) u_ord_ram (
      .clock  (clock),
      .wr_en  (ord_wr_en),
      .wr_addr(ord_wr_addr),
      .wr_data(ord_wr_data),
      .rd_en  (ord_rd_en),
      .rd_addr(ord_rd_addr),
      .rd_data(ord_rd_data)
   );

   assign rec_wr_data = {cls_ff, div_y.value, div_x.value};
   assign new_dist    = manhattan(cx_ff, cy_ff, $signed(rec_rd_data[15:0]),
                                  $signed(rec_rd_data[31:16]));
   assign ord_dist    = ord_rd_data[15:0];
   assign ord_slot    = ord_rd_data[ORD_W-1:16];
   assign last_i      = (CW'(i_ff) + CW'(1)) == n_ff;
   assign emit        = !rsp_valid_ff || rsp_tready;
   assign n_req       = (14'(record_count_ff) > 14'(MAX_RECORDS)) ? CW'(MAX_RECORDS)
                                                                  : CW'(record_count_ff);

   // Sequencer: next state, memory accesses and working registers.
   always_comb begin
      state_in     = state_ff;
      sorted_in    = sorted_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      dist_in      = dist_ff;
      slot_in      = slot_ff;
      fdist_in     = fdist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rec_wr_en    = 1'b0;
      rec_rd_en    = 1'b0;
      rec_rd_addr  = i_ff;
      ord_wr_en    = 1'b0;
      ord_wr_addr  = j_ff;
      ord_wr_data  = {i_ff, dist_ff};
      ord_rd_en    = 1'b0;
      ord_rd_addr  = scan_ff[AW-1:0];
      unique case (state_ff)
         mns_pkg::S_IDLE: begin
            if (req_xfer) begin
               unique case (action)
                  mns_pkg::ACT_LOAD: begin
                     state_in = mns_pkg::S_LOAD_DIV;
                  end
                  mns_pkg::ACT_QUERY: begin
                     n_in = n_req;
                     i_in = '0;
                     if (n_req == '0) begin
                        sorted_in = '0;
                        scan_in   = '0;
                        pend_in   = mns_pkg::STAT_SORTED;
                        state_in  = mns_pkg::S_RESP;
                     end else begin
                        state_in = mns_pkg::S_Q_RDPOS;
                     end
                  end
                  mns_pkg::ACT_FETCH: begin
                     state_in = mns_pkg::S_F_RDORD;
                  end
                  default: begin
                     state_in = mns_pkg::S_IDLE;
                  end
               endcase
            end
         end
         mns_pkg::S_LOAD_DIV: begin
            if (div_x.done) begin
               rec_wr_en = ld_ok_ff;
               pend_in   = mns_pkg::STAT_LOADED;
               state_in  = mns_pkg::S_RESP;
            end
         end
         mns_pkg::S_Q_RDPOS: begin
            rec_rd_en   = 1'b1;
            rec_rd_addr = i_ff;
            state_in    = mns_pkg::S_Q_DIST;
         end
         mns_pkg::S_Q_DIST: begin
            dist_in = new_dist;
            if (i_ff == '0) begin
               // First record goes straight to rank zero.
               ord_wr_en   = 1'b1;
               ord_wr_addr = '0;
               ord_wr_data = {i_ff, new_dist};
               if (last_i) begin
                  sorted_in = n_ff;
                  scan_in   = '0;
                  pend_in   = mns_pkg::STAT_SORTED;
                  state_in  = mns_pkg::S_RESP;
               end else begin
                  i_in     = i_ff + AW'(1);
                  state_in = mns_pkg::S_Q_RDPOS;
               end
            end else begin
               ord_rd_en   = 1'b1;
               ord_rd_addr = i_ff - AW'(1);
               j_in        = i_ff;
               state_in    = mns_pkg::S_Q_SHIFT;
            end
         end
         mns_pkg::S_Q_SHIFT: begin
            ord_wr_en   = 1'b1;
            ord_wr_addr = j_ff;
            if (ord_dist > dist_ff) begin
               // Move the larger entry up one rank and look one lower.
               ord_wr_data = ord_rd_data;
               j_in        = j_ff - AW'(1);
               if (j_ff == AW'(1)) begin
                  state_in = mns_pkg::S_Q_PLACE;
               end else begin
                  ord_rd_en   = 1'b1;
                  ord_rd_addr = j_ff - AW'(2);
               end
            end else begin
               ord_wr_data = {i_ff, dist_ff};
               if (last_i) begin
                  sorted_in = n_ff;
                  scan_in   = '0;
                  pend_in   = mns_pkg::STAT_SORTED;
                  state_in  = mns_pkg::S_RESP;
               end else begin
                  i_in     = i_ff + AW'(1);
                  state_in = mns_pkg::S_Q_RDPOS;
               end
            end
         end
         mns_pkg::S_Q_PLACE: begin
            ord_wr_en   = 1'b1;
            ord_wr_addr = '0;
            ord_wr_data = {i_ff, dist_ff};
            if (last_i) begin
               sorted_in = n_ff;
               scan_in   = '0;
               pend_in   = mns_pkg::STAT_SORTED;
               state_in  = mns_pkg::S_RESP;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = mns_pkg::S_Q_RDPOS;
            end
         end
         mns_pkg::S_F_RDORD: begin
            if (scan_ff >= sorted_ff) begin
               pend_in  = mns_pkg::STAT_NOMATCH;
               state_in = mns_pkg::S_RESP;
            end else begin
               ord_rd_en   = 1'b1;
               ord_rd_addr = scan_ff[AW-1:0];
               scan_in     = scan_ff + CW'(1);
               state_in    = mns_pkg::S_F_RDREC;
            end
         end
         mns_pkg::S_F_RDREC: begin
            slot_in     = ord_slot;
            fdist_in    = ord_dist;
            rec_rd_en   = 1'b1;
            rec_rd_addr = ord_slot;
            state_in    = mns_pkg::S_F_CHECK;
         end
         mns_pkg::S_F_CHECK: begin
            if (rec_rd_data[34:32] >= min_rating_ff) begin
               pend_in  = mns_pkg::STAT_MATCH;
               state_in = mns_pkg::S_RESP;
            end else begin
               state_in = mns_pkg::S_F_RDORD;
            end
         end
         mns_pkg::S_RESP: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               state_in     = mns_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mns_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= mns_pkg::S_IDLE;
         rsp_valid_ff    <= 1'b0;
         sorted_ff       <= '0;
         scan_ff         <= '0;
         min_rating_ff   <= 3'd1;
         record_count_ff <= 11'd1024;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sorted_ff    <= sorted_in;
         scan_ff      <= scan_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               mns_pkg::CSR_MIN_RATING:   min_rating_ff   <= csr_data[2:0];
               mns_pkg::CSR_RECORD_COUNT: record_count_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_ff  <= pend_in;
      n_ff     <= n_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      dist_ff  <= dist_in;
      slot_ff  <= slot_in;
      fdist_ff <= fdist_in;
      if (req_xfer) begin
         ld_slot_ff <= AW'(rec_index);
         ld_ok_ff   <= 14'(rec_index) < 14'(MAX_RECORDS);
         cls_ff     <= rating_class(rec_rating);
         cx_ff      <= cursor_x;
         cy_ff      <= cursor_y;
      end
      if (state_ff == mns_pkg::S_RESP && emit) begin
         rsp_status_ff <= pend_ff;
         rsp_index_ff  <= (pend_ff == mns_pkg::STAT_MATCH) ? 10'(slot_ff) : 10'd0;
         rsp_dist_ff   <= (pend_ff == mns_pkg::STAT_MATCH) ? fdist_ff : 16'd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'b0, rsp_dist_ff, rsp_index_ff};

   // The fetch pointer never passes the end of the sorted list.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= sorted_ff)
      else $error("scan pointer beyond sorted list");

   // While shifting, the rank being filled lies between one and the record index.
   a_shift_rank: assert property (@(posedge clock) disable iff (reset)
      state_ff == mns_pkg::S_Q_SHIFT |-> (j_ff != '0) && (j_ff <= i_ff))
      else $error("insertion rank out of range");

   // The sorted list is never read at the entry written in the same cycle.
   a_ord_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ord_wr_en && ord_rd_en && ord_wr_addr == ord_rd_addr))
      else $error("sorted list read and write collide");

   // Both coordinate mappers finish together.
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      div_x.done == div_y.done)
      else $error("coordinate mappers out of step");

   // A record is written only at the end of a load.
   a_rec_write: assert property (@(posedge clock) disable iff (reset)
      rec_wr_en |-> state_ff == mns_pkg::S_LOAD_DIV && $past(state_ff) == mns_pkg::S_LOAD_DIV)
      else $error("record store written outside a load");

endmodule

// ----- hw/rtl/mns_ram.sv -----
// Simple dual-port synchronous memory with registered read data.
// Depends on no package.
module mns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the read data is registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/mns_map_div.sv -----
// Maps one coordinate to map pixels: (coord - ORIGIN) * 2048 / span, truncated
// toward zero and saturated to 16 bits signed, by reciprocal multiplication.
// Depends on mns_pkg.
module mns_map_div #(
   parameter int ORIGIN  = 0,
   parameter int DIVISOR = 1,
   parameter bit NEGATE  = 1'b0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [24:0]        coord,
   output mns_pkg::mns_div_out_type  result
);

   // The divisor lies between 2^14 and 2^16. Magnitudes of 2^20 and more always
   // saturate; below that, a 33-bit reciprocal scaled by 2^(36+11) gives the exact
   // truncated quotient after a shift by 36.
   localparam int MAG_W  = 20;
   localparam int RW     = 33;
   localparam int PW     = MAG_W + RW;
   localparam int QSHIFT = 36;
   localparam int QW     = PW - QSHIFT;
   localparam longint RECIP_FULL =
      ((longint'(1) << (QSHIFT + mns_pkg::MAP_SHIFT)) + longint'(DIVISOR) - longint'(1))
      / longint'(DIVISOR);
   localparam logic [RW-1:0] RECIP = RW'(RECIP_FULL);

   logic signed [25:0] diff;
   logic [25:0]        mag;
   logic [QW-1:0]      q;

   logic              busy_ff;
   logic              done_ff;
   logic              neg_ff;
   logic              big_ff;
   logic [MAG_W-1:0]  mag_ff;
   logic [PW-1:0]     prod_ff;

   // Offset from the window edge and its magnitude.
   assign diff = 26'(coord) - 26'(ORIGIN);
   assign mag  = diff[25] ? 26'(-diff) : 26'(diff);
   assign q    = prod_ff[PW-1:QSHIFT];

   // Step control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Capture the magnitude, then multiply by the reciprocal.
   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= mag[MAG_W-1:0];
         neg_ff <= diff[25] ^ NEGATE;
         big_ff <= mag[25:MAG_W] != '0;
      end else if (busy_ff) begin
         prod_ff <= PW'(mag_ff) * PW'(RECIP);
      end
   end

   // Sign and saturation of the quotient.
   always_comb begin
      result.done = done_ff;
      if (big_ff || q[QW-1:15] != '0) begin
         result.value = neg_ff ? 16'sh8000 : 16'sh7FFF;
      end else if (neg_ff) begin
         result.value = $signed(-q[15:0]);
      end else begin
         result.value = $signed(q[15:0]);
      end
   end

endmodule

// ----- verif/tb.sv -----
// Testbench for manhattan_nearest_sort: loads records, runs queries and fetches,
// and checks every response against an in-bench prediction of the sorter.
// Depends on mns_pkg and the manhattan_nearest_sort RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  SLOTS     = 1024;
   localparam int  BULK      = 256;
   localparam longint LIMIT  = 3000000;
   localparam int  SETTLE    = 60;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [10:0] csr_data;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  slot;
      logic [15:0] distance;
   } answer_type;

   // Predicted sorter state.
   logic signed [15:0] map_x [SLOTS];
   logic signed [15:0] map_y [SLOTS];
   logic [2:0]         rate_class [SLOTS];
   logic [9:0]         ranked_slot [SLOTS];
   logic [15:0]        ranked_dist [SLOTS];
   int unsigned        scan_ptr;
   int unsigned        ranked_total;
   logic [2:0]         least_class;
   logic [10:0]        active_records;

   answer_type  pending_answers[$];
   int          mismatches;
   int          items_sent;
   longint      cycle_count;
   bit          no_idle;

   manhattan_nearest_sort DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Idle length: mostly none, some short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Map one coordinate to pixels, truncating toward zero, saturated to 16 bits.
   function automatic logic signed [15:0] to_pixel(logic signed [24:0] pos,
                                                   longint origin, longint span);
      longint t;
      t = ((longint'(pos) - origin) * (longint'(1) << mns_pkg::MAP_SHIFT)) / span;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return t[15:0];
   endfunction

   // Advance the predicted state by one accepted request.
   function automatic void predict_request(logic [1:0] act, logic [87:0] d);
      answer_type a;
      int unsigned n, i, j, k;
      longint dx, dy, dsum;
      logic [15:0] rank_dist;
      logic [4:0] cls;
      a = '0;
      case (act)
         mns_pkg::ACT_LOAD: begin
            k = d[9:0];
            map_x[k] = to_pixel(d[34:10], mns_pkg::WEST_EDGE, mns_pkg::X_SPAN);
            map_y[k] = to_pixel(d[59:35], mns_pkg::NORTH_EDGE, -longint'(mns_pkg::Y_SPAN));
            cls = (d[63:60] + 5'd1) / 2;
            if (cls < 1) cls = 1;
            if (cls > 7) cls = 7;
            rate_class[k] = cls[2:0];
            a.status = mns_pkg::STAT_LOADED;
            pending_answers.push_back(a);
         end
         mns_pkg::ACT_QUERY: begin
            n = active_records > SLOTS ? SLOTS : active_records;
            for (i = 0; i < n; i++) begin
               dx = longint'(d[75:64]) - longint'(map_x[i]);
               dy = longint'(d[87:76]) - longint'(map_y[i]);
               dsum = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
               rank_dist = dsum > 65535 ? 16'hFFFF : dsum[15:0];
               // Equal distances keep ascending slot order.
               j = i;
               while (j > 0 && ranked_dist[j-1] > rank_dist) begin
                  ranked_dist[j] = ranked_dist[j-1];
                  ranked_slot[j] = ranked_slot[j-1];
                  j--;
               end
               ranked_dist[j] = rank_dist;
               ranked_slot[j] = i[9:0];
            end
            ranked_total = n;
            scan_ptr = 0;
            a.status = mns_pkg::STAT_SORTED;
            pending_answers.push_back(a);
         end
         mns_pkg::ACT_FETCH: begin
            a.status = mns_pkg::STAT_NOMATCH;
            while (scan_ptr < ranked_total) begin
               k = scan_ptr;
               scan_ptr++;
               if (rate_class[ranked_slot[k]] >= least_class) begin
                  a.status = mns_pkg::STAT_MATCH;
                  a.slot = ranked_slot[k];
                  a.distance = ranked_dist[k];
                  break;
               end
            end
            pending_answers.push_back(a);
         end
         default: ;
      endcase
   endfunction

   // Send one request and record what it should answer. Called just after an edge.
   task automatic send_request(logic [1:0] act, logic [9:0] slot,
                               logic signed [24:0] lon, logic signed [24:0] lat,
                               logic [3:0] rating, logic [11:0] cx, logic [11:0] cy);
      int gap;
      req_tuser  <= act;
      req_tdata  <= {cy, cx, rating, lat, lon, slot};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_request(act, {cy, cx, rating, lat, lon, slot});
      if (act != mns_pkg::ACT_NONE) items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_record(logic [9:0] slot, logic signed [24:0] lon,
                              logic signed [24:0] lat, logic [3:0] rating);
      send_request(mns_pkg::ACT_LOAD, slot, lon, lat, rating, $urandom, $urandom);
   endtask

   task automatic start_query(logic [11:0] cx, logic [11:0] cy);
      send_request(mns_pkg::ACT_QUERY, $urandom, $urandom, $urandom, $urandom, cx, cy);
   endtask

   task automatic fetch_next();
      send_request(mns_pkg::ACT_FETCH, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
   endtask

   task automatic send_unused();
      send_request(mns_pkg::ACT_NONE, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
   endtask

   // Wait for every pending answer, let the block settle, then write a register.
   task automatic write_register(logic idx, logic [10:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == mns_pkg::CSR_MIN_RATING) least_class = value[2:0];
      else active_records = value;
   endtask

   function automatic logic signed [24:0] random_lon();
      if ($urandom_range(0, 9) < 8)
         return 25'(mns_pkg::WEST_EDGE + int'($urandom_range(0, mns_pkg::X_SPAN)));
      return $urandom;
   endfunction

   function automatic logic signed [24:0] random_lat();
      if ($urandom_range(0, 9) < 8)
         return 25'(mns_pkg::SOUTH_EDGE + int'($urandom_range(0, mns_pkg::Y_SPAN)));
      return $urandom;
   endfunction

   // Fetches before any query report no match.
   task automatic test_fetch_before_query();
      fetch_next();
      fetch_next();
   endtask

   // Field extremes on loads, then queries at the cursor corners and at inner points.
   task automatic test_directed();
      int i;
      write_register(mns_pkg::CSR_RECORD_COUNT, 11'd16);
      load_record(10'd0, -25'sd16777216, -25'sd16777216, 4'd0);
      load_record(10'd1, 25'sd16777215, 25'sd16777215, 4'd15);
      load_record(10'd2, 25'(mns_pkg::WEST_EDGE), 25'(mns_pkg::NORTH_EDGE), 4'd10);
      load_record(10'd3, 25'(mns_pkg::EAST_EDGE), 25'(mns_pkg::SOUTH_EDGE), 4'd1);
      for (i = 4; i < 16; i++)
         load_record(i[9:0], random_lon(), random_lat(), i[3:0]);
      load_record(10'd1023, random_lon(), random_lat(), 4'd5);
      send_unused();
      start_query(12'd0, 12'd0);
      for (i = 0; i < 18; i++) fetch_next();
      start_query(12'd4095, 12'd4095);
      fetch_next();
      // A new threshold applies at the next fetch.
      write_register(mns_pkg::CSR_MIN_RATING, 3'd7);
      for (i = 0; i < 4; i++) fetch_next();
      write_register(mns_pkg::CSR_MIN_RATING, 3'd0);
      start_query(12'd1024, 12'd700);
      for (i = 0; i < 17; i++) fetch_next();
      write_register(mns_pkg::CSR_MIN_RATING, 3'd5);
      start_query(12'd2048, 12'd2048);
      for (i = 0; i < 17; i++) fetch_next();
      // An empty query leaves nothing to return.
      write_register(mns_pkg::CSR_RECORD_COUNT, 11'd0);
      start_query(12'd100, 12'd100);
      fetch_next();
   endtask

   // Fill a large block of slots on one spot, so sorting moves nothing, and query it.
   task automatic test_large_store();
      int i;
      no_idle = 1'b1;
      for (i = 0; i < BULK; i++)
         load_record(i[9:0], 25'(mns_pkg::WEST_EDGE + 1000), 25'(mns_pkg::SOUTH_EDGE + 2000),
                     $urandom_range(0, 15));
      no_idle = 1'b0;
      write_register(mns_pkg::CSR_RECORD_COUNT, 11'(BULK));
      write_register(mns_pkg::CSR_MIN_RATING, 3'd1);
      start_query($urandom, $urandom);
      for (i = 0; i < 6; i++) fetch_next();
      write_register(mns_pkg::CSR_RECORD_COUNT, 11'(BULK - 56));
      write_register(mns_pkg::CSR_MIN_RATING, 3'd7);
      start_query($urandom, $urandom);
      for (i = 0; i < 8; i++) fetch_next();
      write_register(mns_pkg::CSR_MIN_RATING, 3'd1);
   endtask

   // Random rounds: set the registers, load, query, then fetch, at times past the end.
   task automatic test_random_rounds();
      int n, i, loads, fetches;
      while (items_sent < 500) begin
         no_idle = ($urandom_range(0, 4) == 0);
         n = $urandom_range(1, 24);
         write_register(mns_pkg::CSR_RECORD_COUNT, n[10:0]);
         write_register(mns_pkg::CSR_MIN_RATING,
                        $urandom_range(0, 9) == 0 ? $urandom_range(0, 7)
                                                   : $urandom_range(1, 5));
         loads = $urandom_range(1, n);
         for (i = 0; i < loads; i++)
            load_record($urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, n - 1),
                        random_lon(), random_lat(), $urandom_range(0, 15));
         if ($urandom_range(0, 5) == 0)
            send_unused();
         start_query($urandom, $urandom);
         fetches = $urandom_range(1, n + 2);
         for (i = 0; i < fetches; i++) fetch_next();
      end
      no_idle = 1'b0;
   endtask

   // Response side: random stalls and the check of each transfer.
   always @(posedge clock) begin
      answer_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: status %0d index %0d distance %0d",
                        rsp_tuser, rsp_tdata[9:0], rsp_tdata[25:10]);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[9:0] !== want.slot ||
                rsp_tdata[25:10] !== want.distance || rsp_tdata[31:26] !== 6'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d (data %h)",
                           want.status, want.slot, want.distance, rsp_tuser,
                           rsp_tdata[9:0], rsp_tdata[25:10], rsp_tdata);
            end
         end
      end
      rsp_tready <= no_idle ? 1'b1 : (pick_gap() == 0);
   end

   initial begin
      mismatches     = 0;
      items_sent     = 0;
      cycle_count    = 0;
      no_idle        = 1'b0;
      scan_ptr       = 0;
      ranked_total   = 0;
      least_class    = 3'd1;
      active_records = 11'd1024;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = 1'b0;
      csr_data   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fetch_before_query();
      test_directed();
      test_large_store();
      test_random_rounds();

      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
